[rtl/core/matrix_multiply_engine_top_defines.svh]
// assertion macros shared by the matrix multiply engine rtl
`ifndef MATRIX_MULTIPLY_ENGINE_TOP_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// checked property, disabled while reset is held
`define MME_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mme assertion failed");

// checked property, also active during reset
`define MME_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("mme assertion failed");

`else

`define MME_ASSERT(lbl, clk, rst_n, prop)
`define MME_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[rtl/core/mme_pkg.sv]
// shared types, codes and constants of the matrix multiply engine
package mme_pkg;

  // default parameter values
  localparam int DEF_MAX_DIM    = 8;
  localparam int DEF_VALUE_BITS = 32;

  // fixed field widths
  localparam int IDX_W     = 3;
  localparam int DIM_W     = 4;
  localparam int FIELD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 2'd3;

  // result status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_MISMATCH = 1'b1;

  // input operations
  typedef enum logic [1:0] {
    OP_WR_A    = 2'd0,
    OP_WR_B    = 2'd1,
    OP_COMPUTE = 2'd2
  } op_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_RND,
    ST_LOAD,
    ST_OUT,
    ST_ERR,
    ST_ERR_OUT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             mul;
    logic             acc_en;
    logic             acc_first;
    logic             rnd;
    logic             load_ok;
    logic             load_err;
    logic             last;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_done;
  } sts_t;

endpackage

[rtl/core/mme_ram.sv]
// generic single write port, single read port ram with registered read
module mme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/mme_ctrl.sv]
// sequencer of the matrix multiply engine: config registers, loop counters, fsm
`include "matrix_multiply_engine_top_defines.svh"

module mme_ctrl #(
  parameter int MAX_DIM = mme_pkg::DEF_MAX_DIM
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_op,
  input  logic                           cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]      cfg_data,
  input  mme_pkg::sts_t                  sts,
  output mme_pkg::cmd_t                  cmd
);

  localparam logic [mme_pkg::DIM_W-1:0] DIM_MAX = mme_pkg::DIM_W'(MAX_DIM);

  mme_pkg::state_t state_r, state_nxt;
  logic [mme_pkg::DIM_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic [mme_pkg::IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [mme_pkg::IDX_W-1:0] ar_last, ac_last, br_last, bc_last;
  logic                      mismatch;
  logic                      elem_last;
  logic                      accept;

  // clamp a dimension register to 1..MAX_DIM and give its last index
  function automatic logic [mme_pkg::IDX_W-1:0] last_idx(
    input logic [mme_pkg::DIM_W-1:0] raw
  );
    logic [mme_pkg::DIM_W-1:0] d;
    d = raw;
    if (raw == '0) begin
      d = mme_pkg::DIM_W'(1);
    end else if (raw > DIM_MAX) begin
      d = DIM_MAX;
    end
    return mme_pkg::IDX_W'(d - mme_pkg::DIM_W'(1));
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= mme_pkg::DIM_W'(8);
      a_cols_r <= mme_pkg::DIM_W'(8);
      b_rows_r <= mme_pkg::DIM_W'(8);
      b_cols_r <= mme_pkg::DIM_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mme_pkg::CFG_A_ROWS: a_rows_r <= cfg_data;
        mme_pkg::CFG_A_COLS: a_cols_r <= cfg_data;
        mme_pkg::CFG_B_ROWS: b_rows_r <= cfg_data;
        mme_pkg::CFG_B_COLS: b_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective dimensions
  assign ar_last   = last_idx(a_rows_r);
  assign ac_last   = last_idx(a_cols_r);
  assign br_last   = last_idx(b_rows_r);
  assign bc_last   = last_idx(b_cols_r);
  assign mismatch  = (ac_last != br_last);
  assign elem_last = (i_r == ar_last) && (j_r == bc_last);

  assign in_stall = (state_r != mme_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // state and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mme_pkg::ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    cmd           = '0;
    cmd.i         = i_r;
    cmd.j         = j_r;
    cmd.k         = k_r;
    cmd.last      = elem_last;
    cmd.acc_first = (k_r == '0);
    unique case (state_r)
      mme_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_op)
            mme_pkg::OP_WR_A: cmd.wr_a = 1'b1;
            mme_pkg::OP_WR_B: cmd.wr_b = 1'b1;
            mme_pkg::OP_COMPUTE: begin
              i_nxt = '0;
              j_nxt = '0;
              k_nxt = '0;
              state_nxt = mismatch ? mme_pkg::ST_ERR : mme_pkg::ST_READ;
            end
            default: ;
          endcase
        end
      end
      mme_pkg::ST_READ: begin
        state_nxt = mme_pkg::ST_MUL;
      end
      mme_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = mme_pkg::ST_ACC;
      end
      mme_pkg::ST_ACC: begin
        cmd.acc_en = 1'b1;
        if (k_r == ac_last) begin
          state_nxt = mme_pkg::ST_RND;
        end else begin
          k_nxt     = k_r + mme_pkg::IDX_W'(1);
          state_nxt = mme_pkg::ST_READ;
        end
      end
      mme_pkg::ST_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = mme_pkg::ST_LOAD;
      end
      mme_pkg::ST_LOAD: begin
        cmd.load_ok = 1'b1;
        state_nxt   = mme_pkg::ST_OUT;
      end
      mme_pkg::ST_OUT: begin
        if (sts.out_done) begin
          k_nxt = '0;
          if (elem_last) begin
            state_nxt = mme_pkg::ST_IDLE;
          end else begin
            state_nxt = mme_pkg::ST_READ;
            if (j_r == bc_last) begin
              j_nxt = '0;
              i_nxt = i_r + mme_pkg::IDX_W'(1);
            end else begin
              j_nxt = j_r + mme_pkg::IDX_W'(1);
            end
          end
        end
      end
      mme_pkg::ST_ERR: begin
        cmd.load_err = 1'b1;
        state_nxt    = mme_pkg::ST_ERR_OUT;
      end
      mme_pkg::ST_ERR_OUT: begin
        if (sts.out_done) begin
          state_nxt = mme_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mme_pkg::ST_IDLE;
    endcase
  end

  // a mismatched compute request goes straight to the error result
  `MME_ASSERT(a_mismatch_err, clk, rst_n, (state_r == mme_pkg::ST_IDLE && accept && in_op == mme_pkg::OP_COMPUTE && mismatch) |=> (state_r == mme_pkg::ST_ERR))
  // a result state is held until its transfer
  `MME_ASSERT(a_out_hold, clk, rst_n, (state_r == mme_pkg::ST_OUT && !sts.out_done) |=> (state_r == mme_pkg::ST_OUT))
  // the final inner step ends the sum
  `MME_ASSERT(a_acc_end, clk, rst_n, (state_r == mme_pkg::ST_ACC && k_r == ac_last) |=> (state_r == mme_pkg::ST_RND))

endmodule

[rtl/core/mme_datapath.sv]
// datapath of the matrix multiply engine: stores, multiplier, accumulator, output register
`include "matrix_multiply_engine_top_defines.svh"

module mme_datapath #(
  parameter int MAX_DIM    = mme_pkg::DEF_MAX_DIM,
  parameter int VALUE_BITS = mme_pkg::DEF_VALUE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [mme_pkg::IDX_W-1:0]         in_row_index,
  input  logic [mme_pkg::IDX_W-1:0]         in_col_index,
  input  logic signed [mme_pkg::FIELD_W-1:0] in_element_value,
  input  mme_pkg::cmd_t                     cmd,
  output mme_pkg::sts_t                     sts,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mme_pkg::IDX_W-1:0]         out_row,
  output logic [mme_pkg::IDX_W-1:0]         out_col,
  output logic signed [mme_pkg::FIELD_W-1:0] out_value,
  output logic                              out_status,
  output logic                              out_last
);

  localparam int VW     = (VALUE_BITS < mme_pkg::FIELD_W) ? VALUE_BITS : mme_pkg::FIELD_W;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PROD_W = 2 * VW;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;
  localparam int Q_W    = ACC_W - mme_pkg::FRAC_BITS;
  localparam logic [mme_pkg::IDX_W:0] DIM_LIM = (mme_pkg::IDX_W + 1)'(MAX_DIM);
  localparam logic signed [Q_W-1:0] SAT_MAX =
    {{(Q_W - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
  localparam logic signed [Q_W-1:0] SAT_MIN =
    {{(Q_W - VW + 1){1'b1}}, {(VW - 1){1'b0}}};

  logic                      in_range;
  logic [ADDR_W-1:0]         wr_addr, a_raddr, b_raddr;
  logic [VW-1:0]             a_rdata, b_rdata;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [Q_W-1:0]     acc_hi;
  logic                      trunc_adj;
  logic signed [Q_W-1:0]     q_r, q_nxt;
  logic signed [VW-1:0]      sat_val;
  logic                      out_valid_r, out_valid_nxt;
  logic [mme_pkg::IDX_W-1:0] out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  logic signed [mme_pkg::FIELD_W-1:0] out_value_r, out_value_nxt;
  logic                      out_status_r, out_status_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      out_done;

  // row-major address of an element
  function automatic logic [ADDR_W-1:0] addr_of(
    input logic [mme_pkg::IDX_W-1:0] r,
    input logic [mme_pkg::IDX_W-1:0] c
  );
    return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
  endfunction

  // element writes outside the stores are dropped
  assign in_range = ({1'b0, in_row_index} < DIM_LIM) && ({1'b0, in_col_index} < DIM_LIM);
  assign wr_addr  = addr_of(in_row_index, in_col_index);
  assign a_raddr  = addr_of(cmd.i, cmd.k);
  assign b_raddr  = addr_of(cmd.k, cmd.j);

  // matrix stores
  mme_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (cmd.wr_a && in_range),
    .waddr (wr_addr),
    .wdata (in_element_value[VW-1:0]),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mme_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (cmd.wr_b && in_range),
    .waddr (wr_addr),
    .wdata (in_element_value[VW-1:0]),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // multiply and accumulate
  always_comb begin
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    if (cmd.mul) begin
      prod_nxt = $signed(a_rdata) * $signed(b_rdata);
    end
    if (cmd.acc_en) begin
      acc_nxt = cmd.acc_first ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
  end

  // drop fraction bits, truncating toward zero
  assign acc_hi    = acc_r[ACC_W-1:mme_pkg::FRAC_BITS];
  assign trunc_adj = acc_r[ACC_W-1] && (|acc_r[mme_pkg::FRAC_BITS-1:0]);
  assign q_nxt     = cmd.rnd ? acc_hi + Q_W'(trunc_adj) : q_r;

  // saturate to the value width
  always_comb begin
    if (q_r > SAT_MAX) begin
      sat_val = SAT_MAX[VW-1:0];
    end else if (q_r < SAT_MIN) begin
      sat_val = SAT_MIN[VW-1:0];
    end else begin
      sat_val = q_r[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    q_r    <= q_nxt;
  end

  // output register
  assign out_done = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_done;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    if (cmd.load_ok) begin
      out_valid_nxt  = 1'b1;
      out_row_nxt    = cmd.i;
      out_col_nxt    = cmd.j;
      out_value_nxt  = mme_pkg::FIELD_W'(sat_val);
      out_status_nxt = mme_pkg::STATUS_OK;
      out_last_nxt   = cmd.last;
    end else if (cmd.load_err) begin
      out_valid_nxt  = 1'b1;
      out_row_nxt    = '0;
      out_col_nxt    = '0;
      out_value_nxt  = '0;
      out_status_nxt = mme_pkg::STATUS_MISMATCH;
      out_last_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_row_r    <= out_row_nxt;
    out_col_r    <= out_col_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_row      = out_row_r;
  assign out_col      = out_col_r;
  assign out_value    = out_value_r;
  assign out_status   = out_status_r;
  assign out_last     = out_last_r;
  assign sts.out_done = out_done;

  // a new result is never loaded over one still waiting
  `MME_ASSERT(a_no_overwrite, clk, rst_n, (cmd.load_ok || cmd.load_err) |-> !out_valid_r)
  // an error result always closes its run
  `MME_ASSERT(a_err_last, clk, rst_n, (out_valid_r && out_status_r == mme_pkg::STATUS_MISMATCH) |-> out_last_r)

endmodule

[rtl/core/matrix_multiply_engine_top.sv]
// Matrix multiply engine: elements of A and B are written one per cycle while idle (op write A /
// write B, addressed by row and column); a compute request then streams every element of A*B in
// row-major order, with last set on the final one, or a single error result with status set
// when the column count of A differs from the row count of B. Values are signed Q16.16; each
// product element is the exact sum of products, truncated toward zero and saturated. A compute
// run is sequenced through the single multiplier and accumulator: each product element takes
// one store read, one multiply and one accumulate per inner step, then truncate, load and
// transfer, which waits out any output stall; the error result takes load and transfer. Input
// is stalled for the whole run. Store entries never written read as undefined.
module matrix_multiply_engine_top #(
  parameter int MAX_DIM    = mme_pkg::DEF_MAX_DIM,
  parameter int VALUE_BITS = mme_pkg::DEF_VALUE_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_op,
  input  logic [mme_pkg::IDX_W-1:0]          in_row_index,
  input  logic [mme_pkg::IDX_W-1:0]          in_col_index,
  input  logic signed [mme_pkg::FIELD_W-1:0] in_element_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mme_pkg::IDX_W-1:0]          out_row,
  output logic [mme_pkg::IDX_W-1:0]          out_col,
  output logic signed [mme_pkg::FIELD_W-1:0] out_value,
  output logic                               out_status,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]          cfg_data
);

  mme_pkg::cmd_t cmd;
  mme_pkg::sts_t sts;

  // sequencer
  mme_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_op),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .cmd       (cmd)
  );

  // stores and arithmetic
  mme_datapath #(
    .MAX_DIM    (MAX_DIM),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_element_value (in_element_value),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_value        (out_value),
    .out_status       (out_status),
    .out_last         (out_last)
  );

endmodule

[tb/tb_top.sv]
// self-checking testbench of the matrix multiply engine: directed table, then random phases
`timescale 1ns / 100ps

module tb_top;
  import mme_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 9;
  localparam int MAX_DIM        = DEF_MAX_DIM;
  localparam int STORE_DEPTH    = MAX_DIM * MAX_DIM;
  localparam int RANDOM_ITEMS   = 400;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int MAX_REPORTS    = 10;
  localparam int TIMEOUT_CYCLES = 2_000_000;

  // op code the block ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_t;

  // one product element as seen on the result port
  typedef struct packed {
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [FIELD_W-1:0] value;
    logic               status;
    logic               last;
  } product_t;

  // one row of the directed table: a dimension setting or an input item
  typedef struct {
    bit                 is_cfg;
    logic [DIM_W-1:0]   ar, ac, br, bc;
    logic [1:0]         op;
    logic [IDX_W-1:0]   row, col;
    logic [FIELD_W-1:0] value;
    bit                 typed;
    product_t           want;
  } step_t;

  localparam product_t MISMATCH_RESULT = '{3'd0, 3'd0, 32'd0, STATUS_MISMATCH, 1'b1};

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                in_op = OP_WR_A;
  logic [IDX_W-1:0]          in_row_index = '0;
  logic [IDX_W-1:0]          in_col_index = '0;
  logic signed [FIELD_W-1:0] in_element_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [IDX_W-1:0]          out_row;
  logic [IDX_W-1:0]          out_col;
  logic signed [FIELD_W-1:0] out_value;
  logic                      out_status;
  logic                      out_last;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = CFG_A_ROWS;
  logic [DIM_W-1:0]          cfg_data = '0;

  // predictor state: element stores, written marks and dimension registers
  logic signed [FIELD_W-1:0] a_mem [STORE_DEPTH];
  logic signed [FIELD_W-1:0] b_mem [STORE_DEPTH];
  bit                        a_written [STORE_DEPTH];
  bit                        b_written [STORE_DEPTH];
  logic [DIM_W-1:0]          dim_a_rows = 4'd8;
  logic [DIM_W-1:0]          dim_a_cols = 4'd8;
  logic [DIM_W-1:0]          dim_b_rows = 4'd8;
  logic [DIM_W-1:0]          dim_b_cols = 4'd8;

  product_t product_q [$];
  step_t    script [$];
  idle_t    idle_mode = IDLE_NONE;
  int       hold_seq = 0;
  logic     hold_on = 1'b0;
  int       fail_cnt = 0;
  int       items_sent = 0;

  matrix_multiply_engine_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_row_index     (in_row_index),
    .in_col_index     (in_col_index),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_value        (out_value),
    .out_status       (out_status),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // clock
  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // dimension register as the block uses it: zero acts as one, large values clamp
  function automatic int eff_dim(logic [DIM_W-1:0] r);
    if (r == 0) return 1;
    if (r > MAX_DIM) return MAX_DIM;
    return int'(r);
  endfunction

  // exact dot product, truncated toward zero and saturated to 32 bits
  function automatic logic [FIELD_W-1:0] dot_value(int i, int j, int n);
    logic signed [79:0] sum;
    logic signed [79:0] q;
    int k;
    sum = '0;
    for (k = 0; k < n; k++)
      sum = sum + a_mem[i * MAX_DIM + k] * b_mem[k * MAX_DIM + j];
    q = sum / 80'sd65536;
    if (q > 80'sd2147483647) return 32'h7FFF_FFFF;
    if (q < -80'sd2147483648) return 32'h8000_0000;
    return q[FIELD_W-1:0];
  endfunction

  // expected results of one compute request
  task automatic predict_product();
    int ar, ac, br, bc, i, j;
    product_t p;
    ar = eff_dim(dim_a_rows);
    ac = eff_dim(dim_a_cols);
    br = eff_dim(dim_b_rows);
    bc = eff_dim(dim_b_cols);
    if (ac != br) begin
      product_q.push_back(MISMATCH_RESULT);
    end else begin
      for (i = 0; i < ar; i++) begin
        for (j = 0; j < bc; j++) begin
          p.row    = IDX_W'(i);
          p.col    = IDX_W'(j);
          p.value  = dot_value(i, j, ac);
          p.status = STATUS_OK;
          p.last   = (i == ar - 1) && (j == bc - 1);
          product_q.push_back(p);
        end
      end
    end
  endtask

  function automatic product_t single_ok(logic [FIELD_W-1:0] v);
    return '{3'd0, 3'd0, v, STATUS_OK, 1'b1};
  endfunction

  function automatic step_t cfg_step(logic [DIM_W-1:0] ar, ac, br, bc);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.ar = ar;
    s.ac = ac;
    s.br = br;
    s.bc = bc;
    return s;
  endfunction

  function automatic step_t item_step(logic [1:0] op, logic [IDX_W-1:0] r, c,
                                      logic [FIELD_W-1:0] v);
    step_t s;
    s = '{default: '0};
    s.op = op;
    s.row = r;
    s.col = c;
    s.value = v;
    return s;
  endfunction

  function automatic step_t checked_step(product_t want);
    step_t s;
    s = item_step(OP_COMPUTE, 3'd0, 3'd0, 32'd0);
    s.typed = 1'b1;
    s.want = want;
    return s;
  endfunction

  // element values: full range, small fractions, integers, extremes
  function automatic logic [FIELD_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      2: return ($urandom_range(0, 15) - 8) << FRAC_BITS;
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] rand_dim();
    if ($urandom_range(0, 9) < 7) return DIM_W'($urandom_range(1, 3));
    return DIM_W'($urandom_range(0, 15));
  endfunction

  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(0, 99) < 65;
      IDLE_BOTH: return $urandom_range(0, 99) < 21;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic logic stall_draw();
    if (hold_on) return 1'b1;
    case (idle_mode)
      IDLE_RECV: return $urandom_range(0, 99) < 65;
      IDLE_BOTH: return $urandom_range(0, 99) < 21;
      default:   return 1'b0;
    endcase
  endfunction

  // one input transfer; valid stays high for a following item with no gap
  task automatic send_item(logic [1:0] op, logic [IDX_W-1:0] r, c,
                           logic [FIELD_W-1:0] v, bit typed, product_t want);
    while (sender_gap()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_row_index     <= r;
    in_col_index     <= c;
    in_element_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge: update the predictor
    if (op == OP_WR_A) begin
      a_mem[r * MAX_DIM + c] = v;
      a_written[r * MAX_DIM + c] = 1'b1;
    end else if (op == OP_WR_B) begin
      b_mem[r * MAX_DIM + c] = v;
      b_written[r * MAX_DIM + c] = 1'b1;
    end else if (op == OP_COMPUTE) begin
      if (typed) product_q.push_back(want);
      else predict_product();
    end
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic send_plain(logic [1:0] op, logic [IDX_W-1:0] r, c, logic [FIELD_W-1:0] v);
    send_item(op, r, c, v, 1'b0, '0);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_A_ROWS: dim_a_rows = val;
      CFG_A_COLS: dim_a_cols = val;
      CFG_B_ROWS: dim_b_rows = val;
      default:    dim_b_cols = val;
    endcase
  endtask

  // drain all results, let the block settle, then write all four dimensions
  task automatic set_dims(logic [DIM_W-1:0] ar, ac, br, bc);
    in_valid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write(CFG_A_ROWS, ar);
    cfg_write(CFG_A_COLS, ac);
    cfg_write(CFG_B_ROWS, br);
    cfg_write(CFG_B_COLS, bc);
    cfg_we <= 1'b0;
  endtask

  // occasional noise: ignored op or a write anywhere in either store
  task automatic maybe_noise();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 2))
        0: send_plain(OP_UNUSED, 3'($urandom), 3'($urandom), $urandom);
        1: send_plain(OP_WR_A, 3'($urandom), 3'($urandom), rand_value());
        default: send_plain(OP_WR_B, 3'($urandom), 3'($urandom), rand_value());
      endcase
    end
  endtask

  // make sure every operand entry the next compute reads is written, refreshing some at random
  task automatic load_operands();
    int ar, ac, br, bc, i, j;
    ar = eff_dim(dim_a_rows);
    ac = eff_dim(dim_a_cols);
    br = eff_dim(dim_b_rows);
    bc = eff_dim(dim_b_cols);
    for (i = 0; i < ar; i++) begin
      for (j = 0; j < ac; j++) begin
        if (!a_written[i * MAX_DIM + j] || $urandom_range(0, 2) == 0) begin
          maybe_noise();
          send_plain(OP_WR_A, IDX_W'(i), IDX_W'(j), rand_value());
        end
      end
    end
    for (i = 0; i < br; i++) begin
      for (j = 0; j < bc; j++) begin
        if (!b_written[i * MAX_DIM + j] || $urandom_range(0, 2) == 0) begin
          maybe_noise();
          send_plain(OP_WR_B, IDX_W'(i), IDX_W'(j), rand_value());
        end
      end
    end
  endtask

  task automatic report(string what, product_t want);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS)
      $display("%s: expected row %0d col %0d value %h status %0b last %0b, got row %0d col %0d value %h status %0b last %0b",
               what, want.row, want.col, want.value, want.status, want.last,
               out_row, out_col, out_value, out_status, out_last);
  endtask

  // result side: compare each transfer with the oldest expected product element
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (product_q.size() == 0) begin
          report("unexpected result", '0);
        end else if ({out_row, out_col, out_value, out_status, out_last} !== product_q[0]) begin
          report("result mismatch", product_q.pop_front());
        end else begin
          void'(product_q.pop_front());
        end
      end
      out_stall <= stall_draw();
    end
  end

  // long receiver hold-off, started by a bump of hold_seq
  initial begin : hold_ctl
    int seen;
    seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen) begin
        seen = hold_seq;
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
      end
    end
  end

  // run limit
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("** matrix_multiply_engine_top: FAILED **");
    $finish;
  end

  // stimulus
  initial begin
    int s, phase, n_comp, goal;
    logic [DIM_W-1:0] ar, ac, br, bc;

    // directed table
    script.push_back(cfg_step(4'd1, 4'd1, 4'd1, 4'd1));
    script.push_back(item_step(OP_WR_A, 3'd0, 3'd0, 32'h0001_0000));
    script.push_back(item_step(OP_WR_B, 3'd0, 3'd0, 32'h0002_0000));
    script.push_back(checked_step(single_ok(32'h0002_0000)));
    // positive overflow saturates
    script.push_back(item_step(OP_WR_A, 3'd0, 3'd0, 32'h7FFF_FFFF));
    script.push_back(item_step(OP_WR_B, 3'd0, 3'd0, 32'h7FFF_FFFF));
    script.push_back(checked_step(single_ok(32'h7FFF_FFFF)));
    // negative overflow saturates
    script.push_back(item_step(OP_WR_B, 3'd0, 3'd0, 32'h8000_0000));
    script.push_back(checked_step(single_ok(32'h8000_0000)));
    // tiny negative product truncates toward zero
    script.push_back(item_step(OP_WR_A, 3'd0, 3'd0, 32'hFFFF_FFFF));
    script.push_back(item_step(OP_WR_B, 3'd0, 3'd0, 32'h0000_0001));
    script.push_back(checked_step(single_ok(32'h0000_0000)));
    // inner dimension mismatch
    script.push_back(cfg_step(4'd1, 4'd2, 4'd1, 4'd1));
    script.push_back(checked_step(MISMATCH_RESULT));
    // clamped columns of A (8) against seven rows of B
    script.push_back(cfg_step(4'd1, 4'd15, 4'd7, 4'd1));
    script.push_back(checked_step(MISMATCH_RESULT));
    // zero dimensions act as one; an ignored op is sent before the compute
    script.push_back(cfg_step(4'd0, 4'd0, 4'd1, 4'd0));
    script.push_back(item_step(OP_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF));
    script.push_back(item_step(OP_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF));
    // two-term sum with fractions and mixed signs, far corners written
    script.push_back(cfg_step(4'd1, 4'd2, 4'd2, 4'd1));
    script.push_back(item_step(OP_WR_A, 3'd0, 3'd1, 32'h0001_8000));
    script.push_back(item_step(OP_WR_B, 3'd1, 3'd0, 32'hFFFF_4000));
    script.push_back(item_step(OP_WR_A, 3'd7, 3'd7, 32'h8000_0000));
    script.push_back(item_step(OP_WR_B, 3'd7, 3'd7, 32'h7FFF_FFFF));
    script.push_back(item_step(OP_COMPUTE, 3'd0, 3'd0, 32'd0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (s = 0; s < script.size(); s++) begin
      if (script[s].is_cfg)
        set_dims(script[s].ar, script[s].ac, script[s].br, script[s].bc);
      else
        send_item(script[s].op, script[s].row, script[s].col, script[s].value,
                  script[s].typed, script[s].want);
    end

    // random phases: new dimensions, idling pattern, operand loads and computes
    goal = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < goal || phase < 8) begin
      if (phase == 0) begin
        // largest size first, which also fills both stores
        ar = 4'd8;
        ac = 4'd15;
        br = 4'd8;
        bc = 4'd15;
      end else begin
        ar = rand_dim();
        ac = rand_dim();
        br = ($urandom_range(0, 9) == 0) ? rand_dim() : ac;
        bc = rand_dim();
      end
      set_dims(ar, ac, br, bc);
      idle_mode <= idle_t'(phase % 4);
      // block fills up behind a long receiver hold-off
      if (phase == 2 || phase == 13) hold_seq <= hold_seq + 1;
      n_comp = (phase == 0) ? 1 : $urandom_range(1, 3);
      repeat (n_comp) begin
        load_operands();
        send_plain(OP_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
      end
      phase++;
    end

    // drain and verdict
    in_valid <= 1'b0;
    while (product_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && product_q.size() == 0)
      $display("** matrix_multiply_engine_top: PASSED **");
    else
      $display("** matrix_multiply_engine_top: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/mme_pkg.sv
rtl/core/mme_ram.sv
rtl/core/mme_ctrl.sv
rtl/core/mme_datapath.sv
rtl/core/matrix_multiply_engine_top.sv
tb/tb_top.sv
